// File: rtl/core/assert_macros.svh
// Assertion shorthands, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PMSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pmsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pmsa_pkg;

  localparam int VOLT_W     = 16;
  localparam int CURR_W     = 16;
  localparam int TAG_W      = 16;
  localparam int MV_W       = 18;
  localparam int MA_W       = 15;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int ENTRY_W    = VOLT_W + CURR_W + TAG_W;
  localparam int IN_DATA_W  = ENTRY_W;
  localparam int OUT_DATA_W = 56;

  // 3.125 mV LSB: mv = (avg * 3125 + 500) / 1000
  localparam int MV_NUM_W = 28;
  localparam int MV_DEN_W = 10;
  localparam logic [11:0]         MV_SCALE = 12'd3125;
  localparam logic [8:0]          MV_ROUND = 9'd500;
  localparam logic [MV_DEN_W-1:0] MV_DIV   = 10'd1000;
  // 1.25 mV LSB: mv = (avg * 5 + 2) / 4
  localparam logic [1:0]          MV1_ROUND = 2'd2;

  localparam logic [MA_W-1:0] MIN_CURRENT_RST = 15'd300;
  localparam logic [MV_W-1:0] MIN_VOLTAGE_RST = 18'd4000;

  typedef enum logic [OP_W-1:0] {
    OP_STORE   = 2'd0,
    OP_PROCESS = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SENSOR_UNKNOWN = 2'd0,
    SENSOR_1MV25   = 2'd1,
    SENSOR_3MV125  = 2'd2
  } sensor_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUBLISHED = 2'd0,
    ST_MIXED_CTX = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_TYPE = 2'd0,
    REG_MIN_CURRENT = 2'd1,
    REG_MIN_VOLTAGE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [CURR_W-1:0] curr;
    logic [VOLT_W-1:0]        volt;
  } sample_t;

endpackage
`default_nettype wire

// File: rtl/core/pmsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pmsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pmsa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned; after iters steps the quotient sits in the low bits.
module pmsa_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 10,
  localparam int IT_W = $clog2(DVD_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire logic [IT_W-1:0]  iters,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] shreg_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [IT_W-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign rem_sh = {rem_r, shreg_r[DVD_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg_r <= dividend;
      rem_r   <= '0;
      dvs_r   <= divisor;
      cnt_r   <= iters;
    end else if (busy_r) begin
      rem_r   <= ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      shreg_r <= {shreg_r[DVD_W-2:0], ge};
      cnt_r   <= cnt_r - IT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = shreg_r;

endmodule
`default_nettype wire

// File: rtl/core/power_monitor_sample_averager.sv
// Power monitor sample averager. Store requests (tuser 0) put a voltage,
// current and context tag into a ring of RING_DEPTH entries while the sensor
// type is known; a full ring overwrites from the oldest slot. Clear requests
// (tuser 2) empty the ring. A process request (tuser 1) walks the ring
// through its single read port, then runs a bit-serial divider one quotient
// bit per cycle: voltage sum by count, optionally the scaled voltage by 1000,
// then current sum by count. An empty batch or unknown sensor skips the walk
// and the divider. The single result appears on the out_ side and is held
// there until taken; no request is taken while a process request is in work.
// Configuration writes are always ready; they are to be made only while the
// block is idle, a rule the user must keep, as the block leaves it unchecked.
`timescale 1ns / 1ps
`default_nettype none
module power_monitor_sample_averager #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: volt_raw[15:0], curr_raw[31:16], context_tag[47:32]
  input  wire logic [pmsa_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [pmsa_pkg::OP_W-1:0]        in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // out_tdata: avg_mv[17:0], avg_ma[32:18], load_ok[33], batch_tag[49:34], zero fill
  output logic      [pmsa_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0]
  output logic      [pmsa_pkg::STATUS_W-1:0]    out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pmsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pmsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import pmsa_pkg::*;

  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int VSUM_W = VOLT_W + CNT_W;
  localparam int ISUM_W = CURR_W + CNT_W;
  localparam int DIV_DW = (VSUM_W > MV_NUM_W) ? VSUM_W : MV_NUM_W;
  localparam int DIV_SW = (CNT_W > MV_DEN_W) ? CNT_W : MV_DEN_W;
  localparam int IT_W   = $clog2(DIV_DW + 1);
  localparam int VSH    = DIV_DW - VSUM_W;
  localparam int MSH    = DIV_DW - MV_NUM_W;
  localparam int PAD_W  = OUT_DATA_W - (MV_W + MA_W + 1 + TAG_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV_V,
    S_SCALE,
    S_DIV_MV,
    S_DIV_I,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [1:0]      sensor_r;
  logic [MA_W-1:0] min_current_r;
  logic [MV_W-1:0] min_voltage_r;
  logic            known;

  // batch bookkeeping
  logic [ADDR_W-1:0] write_slot_r;
  logic [CNT_W-1:0]  filled_count_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  walk_cnt_r;
  logic              rd_vld_r;
  logic              rd_first_r;
  logic              mismatch_r;

  // datapath
  logic [VSUM_W-1:0]        vsum_r;
  logic signed [ISUM_W-1:0] isum_r;
  logic [TAG_W-1:0]         tag0_r;
  logic [VOLT_W-1:0]        vavg_r;
  logic [MV_W-1:0]          mv_r;
  logic [MA_W-1:0]          ma_r;
  status_t                  status_r;
  logic [VSUM_W-1:0]        ipos;
  logic [MV_NUM_W-1:0]      mv_num;
  logic [VOLT_W+2:0]        mv5;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [MV_W-1:0]   out_mv_r;
  logic [MA_W-1:0]   out_ma_r;
  logic              out_load_ok_r;
  logic [TAG_W-1:0]  out_tag_r;

  // ring
  logic                ram_we;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  sample_t             rd_entry;
  logic                walk_more;
  logic                walk_end;

  // divider
  logic              div_start;
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_SW-1:0] div_dvs;
  logic [IT_W-1:0]   div_iters;
  logic              div_done;
  logic [DIV_DW-1:0] div_q;

  assign known = (sensor_r == SENSOR_1MV25) || (sensor_r == SENSOR_3MV125);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r      <= SENSOR_UNKNOWN;
      min_current_r <= MIN_CURRENT_RST;
      min_voltage_r <= MIN_VOLTAGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSOR_TYPE: sensor_r      <= cfg_data[1:0];
        REG_MIN_CURRENT: min_current_r <= cfg_data[MA_W-1:0];
        REG_MIN_VOLTAGE: min_voltage_r <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign ram_we    = in_tvalid && in_tready && (in_tuser == OP_STORE) && known;
  assign walk_more = (walk_cnt_r != n_r);
  assign walk_end  = !walk_more && !rd_vld_r;
  assign ram_re    = (state_r == S_WALK) && walk_more;
  assign rd_entry  = sample_t'(ram_rdata);

  pmsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot_r),
    .wdata (in_tdata[ENTRY_W-1:0]),
    .re    (ram_re),
    .raddr (walk_cnt_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // negative current sums clamp to zero
  assign ipos   = isum_r[ISUM_W-1] ? '0 : VSUM_W'($unsigned(isum_r));
  assign mv_num = MV_NUM_W'(vavg_r) * MV_NUM_W'(MV_SCALE) + MV_NUM_W'(MV_ROUND);
  assign mv5    = (VOLT_W+3)'({vavg_r, 2'b00}) + (VOLT_W+3)'(vavg_r)
                + (VOLT_W+3)'(MV1_ROUND);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DIV_DW'(ipos) << VSH;
    div_dvs   = DIV_SW'(n_r);
    div_iters = IT_W'(VSUM_W);
    case (state_r)
      S_WALK: begin
        div_start = walk_end && !mismatch_r;
        div_dvd   = DIV_DW'(vsum_r) << VSH;
      end
      S_SCALE: begin
        div_start = 1'b1;
        if (sensor_r == SENSOR_3MV125) begin
          div_dvd   = DIV_DW'(mv_num) << MSH;
          div_dvs   = DIV_SW'(MV_DIV);
          div_iters = IT_W'(MV_NUM_W);
        end
      end
      S_DIV_MV: div_start = div_done;
      default: ;
    endcase
  end

  pmsa_div #(
    .DVD_W (DIV_DW),
    .DVS_W (DIV_SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      write_slot_r   <= '0;
      filled_count_r <= '0;
      rd_vld_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            case (op_t'(in_tuser))
              OP_STORE: begin
                if (known) begin
                  write_slot_r <= (write_slot_r == ADDR_W'(RING_DEPTH - 1)) ? '0
                                : write_slot_r + ADDR_W'(1);
                  if (filled_count_r != CNT_W'(RING_DEPTH)) begin
                    filled_count_r <= filled_count_r + CNT_W'(1);
                  end
                end
              end
              OP_CLEAR: begin
                filled_count_r <= '0;
                write_slot_r   <= '0;
              end
              OP_PROCESS: begin
                filled_count_r <= '0;
                write_slot_r   <= '0;
                n_r            <= filled_count_r;
                walk_cnt_r     <= '0;
                rd_vld_r       <= 1'b0;
                rd_first_r     <= 1'b1;
                mismatch_r     <= 1'b0;
                vsum_r         <= '0;
                isum_r         <= '0;
                if (filled_count_r == '0 || !known) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_OUT;
                end else begin
                  state_r  <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          rd_vld_r <= walk_more;
          if (walk_more) begin
            walk_cnt_r <= walk_cnt_r + CNT_W'(1);
          end
          if (rd_vld_r) begin
            vsum_r     <= vsum_r + VSUM_W'(rd_entry.volt);
            isum_r     <= isum_r + ISUM_W'(rd_entry.curr);
            rd_first_r <= 1'b0;
            if (rd_first_r) begin
              tag0_r <= rd_entry.tag;
            end else if (rd_entry.tag != tag0_r) begin
              mismatch_r <= 1'b1;
            end
          end
          if (walk_end) begin
            if (mismatch_r) begin
              status_r <= ST_MIXED_CTX;
              state_r  <= S_OUT;
            end else begin
              state_r  <= S_DIV_V;
            end
          end
        end
        S_DIV_V: begin
          if (div_done) begin
            vavg_r  <= div_q[VOLT_W-1:0];
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (sensor_r == SENSOR_3MV125) begin
            state_r <= S_DIV_MV;
          end else begin
            mv_r    <= MV_W'(mv5[VOLT_W+2:2]);
            state_r <= S_DIV_I;
          end
        end
        S_DIV_MV: begin
          if (div_done) begin
            mv_r    <= div_q[MV_W-1:0];
            state_r <= S_DIV_I;
          end
        end
        S_DIV_I: begin
          if (div_done) begin
            ma_r     <= div_q[MA_W-1:0];
            status_r <= ST_PUBLISHED;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            if (status_r == ST_PUBLISHED) begin
              out_mv_r      <= mv_r;
              out_ma_r      <= ma_r;
              out_load_ok_r <= (ma_r >= min_current_r) && (mv_r >= min_voltage_r);
              out_tag_r     <= tag0_r;
            end else begin
              out_mv_r      <= '0;
              out_ma_r      <= '0;
              out_load_ok_r <= 1'b0;
              out_tag_r     <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {PAD_W'(0), out_tag_r, out_load_ok_r, out_ma_r, out_mv_r};

`include "assert_macros.svh"

  `PMSA_ASSERT_NXT(a_process_empties, in_tvalid && in_tready && in_tuser == OP_PROCESS, filled_count_r == '0 && write_slot_r == '0, "process request left the batch filled")
  `PMSA_ASSERT_IMP(a_load_ok_thresholds, out_tvalid && out_load_ok_r, out_ma_r >= min_current_r && out_mv_r >= min_voltage_r, "load_ok set below a threshold")
  `PMSA_ASSERT_IMP(a_dropped_zero, out_tvalid && out_status_r != ST_PUBLISHED, out_tdata == '0, "unpublished result carries data")

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pmsa_pkg::*;

  localparam int RING_DEPTH   = 8;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic [MV_W-1:0]  mv;
    logic [MA_W-1:0]  ma;
    logic             ok;
    logic [TAG_W-1:0] tag;
  } batch_result_t;

  class averager_scoreboard;
    logic [1:0]               sensor;
    logic [MA_W-1:0]          min_ma;
    logic [MV_W-1:0]          min_mv;
    logic [VOLT_W-1:0]        ring_volt[RING_DEPTH];
    logic signed [CURR_W-1:0] ring_curr[RING_DEPTH];
    logic [TAG_W-1:0]         ring_tag[RING_DEPTH];
    int                       wr_slot;
    int                       filled;
    batch_result_t            pending_results[$];
    int                       n_errors;
    int                       n_published;
    int                       n_mixed;
    int                       n_empty;

    function new();
      sensor      = SENSOR_UNKNOWN;
      min_ma      = MIN_CURRENT_RST;
      min_mv      = MIN_VOLTAGE_RST;
      wr_slot     = 0;
      filled      = 0;
      n_errors    = 0;
      n_published = 0;
      n_mixed     = 0;
      n_empty     = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_SENSOR_TYPE: sensor = d[1:0];
        REG_MIN_CURRENT: min_ma = d[MA_W-1:0];
        REG_MIN_VOLTAGE: min_mv = d[MV_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [VOLT_W-1:0] volt,
                               logic [CURR_W-1:0] curr, logic [TAG_W-1:0] tag);
      bit            known;
      bit            mixed;
      int unsigned   vsum;
      int unsigned   vavg;
      int unsigned   mv_full;
      int            isum;
      int            ma_full;
      batch_result_t r;
      known = (sensor == SENSOR_1MV25) || (sensor == SENSOR_3MV125);
      case (op)
        OP_STORE: begin
          if (known) begin
            ring_volt[wr_slot] = volt;
            ring_curr[wr_slot] = curr;
            ring_tag[wr_slot]  = tag;
            wr_slot = (wr_slot + 1) % RING_DEPTH;
            if (filled < RING_DEPTH) filled++;
          end
        end
        OP_CLEAR: begin
          filled  = 0;
          wr_slot = 0;
        end
        OP_PROCESS: begin
          r.status = ST_EMPTY;
          r.mv     = '0;
          r.ma     = '0;
          r.ok     = 1'b0;
          r.tag    = '0;
          if (filled != 0) begin
            if (known) begin
              mixed = 0;
              for (int i = 1; i < filled; i++)
                if (ring_tag[i] != ring_tag[0]) mixed = 1;
              if (mixed) begin
                r.status = ST_MIXED_CTX;
              end else begin
                vsum = 0;
                isum = 0;
                for (int i = 0; i < filled; i++) begin
                  vsum += ring_volt[i];
                  isum += int'(ring_curr[i]);
                end
                if (isum < 0) isum = 0;
                vavg = vsum / filled;
                if (sensor == SENSOR_3MV125) mv_full = (vavg * 3125 + 500) / 1000;
                else mv_full = (vavg * 5 + 2) / 4;
                ma_full  = isum / filled;
                r.status = ST_PUBLISHED;
                r.mv     = MV_W'(mv_full);
                r.ma     = MA_W'(ma_full);
                r.ok     = (r.ma >= min_ma) && (r.mv >= min_mv);
                r.tag    = ring_tag[0];
              end
            end
            filled  = 0;
            wr_slot = 0;
          end
          pending_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data);
      batch_result_t e;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual status %0d data %h",
                 $time, st, data);
        return;
      end
      e = pending_results.pop_front();
      case (e.status)
        ST_PUBLISHED: n_published++;
        ST_MIXED_CTX: n_mixed++;
        default:      n_empty++;
      endcase
      check_field("status", 32'(e.status), 32'(st));
      check_field("avg_mv", 32'(e.mv), 32'(data[17:0]));
      check_field("avg_ma", 32'(e.ma), 32'(data[32:18]));
      check_field("load_ok", 32'(e.ok), 32'(data[33]));
      check_field("batch_tag", 32'(e.tag), 32'(data[49:34]));
      check_field("pad", 32'd0, 32'(data[OUT_DATA_W-1:50]));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  averager_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int cycle_count;
  int n_requests;
  int n_settings;

  power_monitor_sample_averager #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // receiver; a hold-off request from the main flow blocks it outright
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [VOLT_W-1:0] rand_volt();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      2, 3, 4: return VOLT_W'($urandom);
      default: return VOLT_W'($urandom_range(8000));
    endcase
  endfunction

  function automatic logic [CURR_W-1:0] rand_curr();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return CURR_W'($urandom);
      5:       return CURR_W'(0 - $urandom_range(500));
      default: return CURR_W'($urandom_range(4000));
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [VOLT_W-1:0] volt,
                              input logic [CURR_W-1:0] curr, input logic [TAG_W-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {tag, curr, volt};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, volt, curr, tag);
    n_requests++;
  endtask

  // drop the input, drain all results and let a store still in flight finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setting(input logic [1:0] sensor, input logic [MA_W-1:0] ma,
                               input logic [MV_W-1:0] mv);
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(sensor));
    write_reg(REG_MIN_CURRENT, CFG_DATA_W'(ma));
    write_reg(REG_MIN_VOLTAGE, CFG_DATA_W'(mv));
    n_settings++;
  endtask

  // mostly complete batches (occasionally overflowing the ring or with one
  // odd tag), the rest lone process/clear/store requests and unused opcodes
  task automatic run_traffic(input int n_items);
    int               sent;
    int               len;
    int               odd_slot;
    int               pick;
    logic [TAG_W-1:0] tag;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        tag = ($urandom_range(3) == 0) ? TAG_W'($urandom_range(3)) : TAG_W'($urandom);
        odd_slot = ($urandom_range(5) == 0) ? $urandom_range(len - 1) : -1;
        for (int k = 0; k < len; k++)
          send_request(OP_STORE, rand_volt(), rand_curr(),
                       (k == odd_slot) ? tag ^ TAG_W'(1 << $urandom_range(15)) : tag);
        send_request(($urandom_range(9) == 0) ? OP_CLEAR : OP_PROCESS,
                     VOLT_W'($urandom), CURR_W'($urandom), TAG_W'($urandom));
        sent += len + 1;
      end else begin
        if (pick < 85)
          send_request(OP_PROCESS, VOLT_W'($urandom), CURR_W'($urandom), TAG_W'($urandom));
        else if (pick < 92)
          send_request(OP_CLEAR, VOLT_W'($urandom), CURR_W'($urandom), TAG_W'($urandom));
        else if (pick < 96)
          send_request(OP_UNUSED, VOLT_W'($urandom), CURR_W'($urandom), TAG_W'($urandom));
        else
          send_request(OP_STORE, rand_volt(), rand_curr(), TAG_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [1:0] sensor;
    int         pick;
    sb              = new();
    rst_n           = 1'b0;
    in_tdata        = '0;
    in_tuser        = OP_STORE;
    in_tvalid       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SENSOR_TYPE;
    cfg_data        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    cycle_count     = 0;
    n_requests      = 0;
    n_settings      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sensor unknown after reset: store ignored, process reports empty
    send_request(OP_STORE, '1, 16'h7FFF, '1);
    send_request(OP_PROCESS, '0, '0, '0);
    settle();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(SENSOR_1MV25));
    send_request(OP_STORE, '1, 16'h7FFF, '1);
    send_request(OP_STORE, '1, 16'h7FFF, '1);
    send_request(OP_PROCESS, '0, '0, '0);
    // negative current sum clamps to zero
    send_request(OP_STORE, '0, 16'h8000, '0);
    send_request(OP_PROCESS, '0, '0, '0);
    send_request(OP_PROCESS, '0, '0, '0);
    send_request(OP_STORE, 16'd100, 16'd100, 16'd1);
    send_request(OP_STORE, 16'd100, 16'd100, 16'd2);
    send_request(OP_PROCESS, '0, '0, '0);
    send_request(OP_STORE, 16'd500, 16'd500, 16'd7);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_PROCESS, '0, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1);
    // ring overflow: nine stores, the first is overwritten
    for (int k = 0; k < RING_DEPTH + 1; k++)
      send_request(OP_STORE, VOLT_W'(1000 * k + 3), CURR_W'(400 + k), 16'h5A5A);
    send_request(OP_PROCESS, '0, '0, '0);
    settle();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(SENSOR_3MV125));
    send_request(OP_STORE, '1, 16'd1000, 16'h8001);
    send_request(OP_PROCESS, '0, '0, '0);
    // batch held when the sensor becomes unknown is discarded
    send_request(OP_STORE, 16'd1234, 16'd50, 16'h0003);
    settle();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(2'd3));
    send_request(OP_PROCESS, '0, '0, '0);
    settle();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(SENSOR_1MV25));
    send_request(OP_PROCESS, '0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      for (int chunk = 0; chunk < 5; chunk++) begin
        settle();
        if (phase == 0 && chunk == 0) begin
          write_setting(SENSOR_3MV125, '0, '0);
        end else if (phase == 0 && chunk == 1) begin
          write_setting(SENSOR_1MV25, '1, '1);
        end else if (phase == 1 && chunk == 2) begin
          write_setting(2'd3, MA_W'($urandom), MV_W'($urandom));
        end else begin
          pick = $urandom_range(19);
          if (pick < 9) sensor = SENSOR_1MV25;
          else if (pick < 17) sensor = SENSOR_3MV125;
          else if (pick < 19) sensor = SENSOR_UNKNOWN;
          else sensor = 2'd3;
          write_setting(sensor,
                        ($urandom_range(3) == 0) ? MA_W'($urandom) : MA_W'($urandom_range(3000)),
                        ($urandom_range(3) == 0) ? MV_W'($urandom) : MV_W'($urandom_range(60000)));
        end
        if (chunk == 0) begin
          case (phase)
            0: begin send_idle_pct = 13; recv_stall_pct = 64; end
            1: begin send_idle_pct = 64; recv_stall_pct = 13; end
            default: begin
              send_idle_pct   = 0;
              recv_stall_pct  = 0;
              hold_off_cycles = 600;  // output blocked, input backs up behind it
            end
          endcase
        end
        run_traffic(110);
      end
    end

    settle();
    $display("Ran %0d requests over %0d register settings, every opcode and sensor type",
             n_requests, n_settings);
    $display("Results: %0d published, %0d mixed-context drops, %0d empty or unknown sensor",
             sb.n_published, sb.n_mixed, sb.n_empty);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pmsa_pkg.sv
rtl/core/pmsa_ram.sv
rtl/core/pmsa_div.sv
rtl/core/power_monitor_sample_averager.sv
sim/tb_top.sv
